FILE: rtl/assert_macros.svh
// Assertion shorthands, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RSF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// antecedent implies consequent in the next cycle
`define RSF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

FILE: rtl/rsf_pkg.sv
package rsf_pkg;

	localparam int SMP_W = 16;
	localparam int WRK_W = 24;
	localparam int TW_W  = 17;
	localparam int LEN_W = 7;

	localparam logic signed [TW_W-1:0] QSINE [17] = '{
		17'sd0, 17'sd3212, 17'sd6393, 17'sd9512, 17'sd12540, 17'sd15447, 17'sd18205,
		17'sd20788, 17'sd23170, 17'sd25330, 17'sd27246, 17'sd28899, 17'sd30274,
		17'sd31357, 17'sd32138, 17'sd32610, 17'sd32768
	};

	typedef struct packed {
		logic signed [WRK_W-1:0] re;
		logic signed [WRK_W-1:0] im;
	} pair_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
	} job_t;

	typedef enum logic [4:0] {
		BK_IDLE, BK_PK_E, BK_PK_O, BK_PK_W,
		BK_BF_RD, BK_BF_MUL, BK_BF_WA, BK_BF_WB,
		BK_SP0_RD, BK_SP0_WA, BK_SP0_WB,
		BK_SP_RD, BK_SP_X, BK_SP_MUL, BK_SP_W,
		BK_EM_RD, BK_EM_LD
	} bk_state_t;

	function automatic logic signed [TW_W-1:0] sine64(input logic [5:0] n);
		logic signed [TW_W-1:0] v;
		v = n[4] ? QSINE[5'd16 - {1'b0, n[3:0]}] : QSINE[{1'b0, n[3:0]}];
		return n[5] ? -v : v;
	endfunction

	function automatic logic signed [TW_W-1:0] cosine64(input logic [5:0] n);
		return sine64(n + 6'd16);
	endfunction

	function automatic logic signed [WRK_W-1:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -48'sd8388608) begin
			return 24'sh800000;
		end
		return v[WRK_W-1:0];
	endfunction

	function automatic logic signed [WRK_W-1:0] negsat24(input logic signed [WRK_W-1:0] v);
		return (v == 24'sh800000) ? 24'sh7FFFFF : -v;
	endfunction

endpackage

FILE: rtl/rsf_front.sv
module rsf_front #(
	parameter int N_POINTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [15:0] sample
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [5:0]                  cfg_data,  // [5:0] frame_order
	output logic                        job_push,
	output rsf_pkg::job_t               job,
	input  logic                        q_full,
	input  logic                        frame_free,
	input  logic [$clog2(N_POINTS)-1:0] smp_addr,
	output logic [rsf_pkg::SMP_W-1:0]   smp_data
);
	import rsf_pkg::*;

	localparam int AW  = $clog2(N_POINTS);
	localparam int LCW = AW + 1;

	logic [5:0]       frame_order_q;
	logic [LCW-1:0]   load_count_q;
	logic             busy_q;
	logic [SMP_W-1:0] smem [N_POINTS];
	logic [LEN_W-1:0] len;
	logic [LCW-1:0]   lc_nxt;
	logic             acc;
	logic             close;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q && !q_full;
	assign acc       = s_tvalid && s_tready;
	assign len       = (LEN_W'(frame_order_q) + 7'd1 > LEN_W'(N_POINTS)) ?
		LEN_W'(N_POINTS) : LEN_W'(frame_order_q) + 7'd1;
	assign lc_nxt    = load_count_q + LCW'(1);
	assign close     = LEN_W'(lc_nxt) >= len;
	assign job_push  = acc && close;
	assign job.len   = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_order_q <= 6'd63;
			load_count_q  <= '0;
			busy_q        <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_order_q <= cfg_data;
			end
			if (acc) begin
				load_count_q <= close ? '0 : lc_nxt;
			end
			if (job_push) begin
				busy_q <= 1'b1;
			end else if (frame_free) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			smem[load_count_q[AW-1:0]] <= s_tdata;
		end
		smp_data <= smem[smp_addr];
	end

endmodule

FILE: rtl/rsf_queue.sv
module rsf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rsf_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output rsf_pkg::job_t dout,
	output logic          empty
);
	import rsf_pkg::*;

	job_t       mem [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= din;
		end
	end

endmodule

FILE: rtl/rsf_back.sv
module rsf_back #(
	parameter int N_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  rsf_pkg::job_t                 job,
	output logic                          q_pop,
	output logic                          frame_free,
	output logic [$clog2(N_POINTS)-1:0]   smp_addr,
	input  logic [rsf_pkg::SMP_W-1:0]     smp_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [55:0]                   m_tdata,
	output logic                          m_tlast
);
	import rsf_pkg::*;

	localparam int HALF  = N_POINTS / 2;
	localparam int AW    = $clog2(HALF);
	localparam int KW    = AW + 1;
	localparam int TSH   = 6 - $clog2(N_POINTS);
	localparam logic [AW-1:0] JLAST = AW'(HALF / 2 - 1);
	localparam logic [AW-1:0] ILAST = AW'(HALF - 1);
	localparam logic [2:0]    SLAST = 3'(AW - 1);

	bk_state_t st_q, st_d;

	logic [LEN_W-1:0] len_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    j_q;
	logic [2:0]       s_q;
	logic [KW-1:0]    k_q;

	pair_t wmem [HALF];
	pair_t rd_a_q, rd_b_q;
	pair_t bdat_q;
	pair_t smem [HALF+1];
	pair_t sp_rd_q;

	logic signed [WRK_W-1:0] re_q;
	logic signed [40:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
	logic signed [24:0] xt_q, yt_q, sr_q, di_q;
	logic signed [TW_W-1:0] c_q, sn_q;
	logic signed [41:0] cyt_q, sxt_q, syt_q, cxt_q;

	logic            out_free;
	logic [5:0]      o_bin_q;
	logic [WRK_W-1:0] o_re_q, o_im_q;
	logic            o_last_q;

	logic [AW-1:0] lowmask, ba, bb, ra, rb, wa;
	logic [5:0]    tw_idx;
	logic          we;
	pair_t         wd;
	logic          swe;
	logic [KW-1:0] swa, sra;
	pair_t         swd;
	logic signed [41:0] vr_t, vi_t;
	logic signed [WRK_W-1:0] vr, vi;
	logic signed [47:0] nr, ni;
	logic [KW-1:0] even_idx, odd_idx;

	function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int b = 0; b < AW; b++) begin
			r[AW-1-b] = v[b];
		end
		return r;
	endfunction

	assign lowmask  = ~({AW{1'b1}} << s_q);
	assign ba       = ((j_q >> s_q) << (s_q + 3'd1)) | (j_q & lowmask);
	assign bb       = ba | (AW'(1) << s_q);
	assign tw_idx   = 6'(j_q & lowmask) << (3'd5 - s_q);
	assign even_idx = {i_q, 1'b0};
	assign odd_idx  = {i_q, 1'b1};
	assign smp_addr = {i_q, st_q == BK_PK_O};
	assign out_free = !m_tvalid || m_tready;

	assign vr_t = p_rc_q + p_is_q + 42'sd16384;
	assign vi_t = p_ic_q - p_rs_q + 42'sd16384;
	assign vr   = WRK_W'(vr_t >>> 15);
	assign vi   = WRK_W'(vi_t >>> 15);
	assign nr   = (48'(sr_q) <<< 15) + 48'(cyt_q) - 48'(sxt_q) + 48'sd32768;
	assign ni   = (48'(di_q) <<< 15) + 48'(syt_q) + 48'(cxt_q) + 48'sd32768;

	always_comb begin
		ra = '0;
		rb = '0;
		case (st_q)
			BK_BF_RD, BK_BF_MUL, BK_BF_WA, BK_BF_WB: begin
				ra = ba;
				rb = bb;
			end
			BK_SP_RD, BK_SP_X, BK_SP_MUL, BK_SP_W: begin
				ra = i_q;
				rb = AW'(0) - i_q;
			end
			default: begin
			end
		endcase
		sra = (k_q <= KW'(HALF)) ? k_q : KW'(N_POINTS) - k_q;
	end

	always_comb begin
		st_d       = st_q;
		q_pop      = 1'b0;
		frame_free = 1'b0;
		we         = 1'b0;
		wa         = ba;
		wd         = bdat_q;
		swe        = 1'b0;
		swa        = KW'(i_q);
		swd.re     = sat24((nr + 48'sd0) >>> 16);
		swd.im     = sat24(ni >>> 16);
		case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					st_d  = BK_PK_E;
				end
			end
			BK_PK_E: st_d = BK_PK_O;
			BK_PK_O: st_d = BK_PK_W;
			BK_PK_W: begin
				we    = 1'b1;
				wa    = bitrev(i_q);
				wd.re = re_q;
				wd.im = (LEN_W'(odd_idx) < len_q) ?
					WRK_W'($signed(smp_data)) : '0;
				if (i_q == ILAST) begin
					frame_free = 1'b1;
					st_d       = BK_BF_RD;
				end else begin
					st_d = BK_PK_E;
				end
			end
			BK_BF_RD:  st_d = BK_BF_MUL;
			BK_BF_MUL: st_d = BK_BF_WA;
			BK_BF_WA: begin
				we    = 1'b1;
				wa    = ba;
				wd.re = rd_a_q.re + vr;
				wd.im = rd_a_q.im + vi;
				st_d  = BK_BF_WB;
			end
			BK_BF_WB: begin
				we = 1'b1;
				wa = bb;
				wd = bdat_q;
				if (j_q == JLAST && s_q == SLAST) begin
					st_d = BK_SP0_RD;
				end else begin
					st_d = BK_BF_RD;
				end
			end
			BK_SP0_RD: st_d = BK_SP0_WA;
			BK_SP0_WA: begin
				swe    = 1'b1;
				swa    = '0;
				swd.re = sat24(48'(rd_a_q.re) + 48'(rd_a_q.im));
				swd.im = '0;
				st_d   = BK_SP0_WB;
			end
			BK_SP0_WB: begin
				swe    = 1'b1;
				swa    = KW'(HALF);
				swd.re = sat24(48'(rd_a_q.re) - 48'(rd_a_q.im));
				swd.im = '0;
				st_d   = (HALF > 1) ? BK_SP_RD : BK_EM_RD;
			end
			BK_SP_RD:  st_d = BK_SP_X;
			BK_SP_X:   st_d = BK_SP_MUL;
			BK_SP_MUL: st_d = BK_SP_W;
			BK_SP_W: begin
				swe  = 1'b1;
				st_d = (i_q == ILAST) ? BK_EM_RD : BK_SP_RD;
			end
			BK_EM_RD: st_d = BK_EM_LD;
			BK_EM_LD: begin
				if (out_free) begin
					st_d = (k_q == KW'(N_POINTS - 1)) ? BK_IDLE : BK_EM_RD;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_EM_LD && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q  <= wmem[ra];
		rd_b_q  <= wmem[rb];
		sp_rd_q <= smem[sra];
		if (we) begin
			wmem[wa] <= wd;
		end
		if (swe) begin
			smem[swa] <= swd;
		end
		case (st_q)
			BK_IDLE: begin
				len_q <= job.len;
				i_q   <= '0;
			end
			BK_PK_O: begin
				re_q <= (LEN_W'(even_idx) < len_q) ? WRK_W'($signed(smp_data)) : '0;
			end
			BK_PK_W: begin
				i_q <= i_q + AW'(1);
				j_q <= '0;
				s_q <= '0;
			end
			BK_BF_MUL: begin
				p_rc_q <= rd_b_q.re * cosine64(tw_idx);
				p_is_q <= rd_b_q.im * sine64(tw_idx);
				p_ic_q <= rd_b_q.im * cosine64(tw_idx);
				p_rs_q <= rd_b_q.re * sine64(tw_idx);
			end
			BK_BF_WA: begin
				bdat_q.re <= rd_a_q.re - vr;
				bdat_q.im <= rd_a_q.im - vi;
			end
			BK_BF_WB: begin
				if (j_q == JLAST) begin
					j_q <= '0;
					s_q <= s_q + 3'd1;
				end else begin
					j_q <= j_q + AW'(1);
				end
			end
			BK_SP0_WB: i_q <= AW'(1);
			BK_SP_X: begin
				xt_q <= rd_a_q.re - rd_b_q.re;
				yt_q <= rd_a_q.im + rd_b_q.im;
				sr_q <= rd_a_q.re + rd_b_q.re;
				di_q <= rd_b_q.im - rd_a_q.im;
				c_q  <= cosine64(6'(i_q) << TSH);
				sn_q <= sine64(6'(i_q) << TSH);
			end
			BK_SP_MUL: begin
				cyt_q <= c_q * yt_q;
				sxt_q <= sn_q * xt_q;
				syt_q <= sn_q * yt_q;
				cxt_q <= c_q * xt_q;
			end
			BK_SP_W: begin
				i_q <= i_q + AW'(1);
				k_q <= '0;
			end
			BK_EM_LD: begin
				if (out_free) begin
					o_bin_q  <= 6'(k_q);
					o_re_q   <= sp_rd_q.re;
					o_im_q   <= (k_q < KW'(HALF)) ? negsat24(sp_rd_q.im) : sp_rd_q.im;
					o_last_q <= k_q == KW'(N_POINTS - 1);
					k_q      <= k_q + KW'(1);
				end
			end
			default: begin
			end
		endcase
		if (st_q == BK_SP0_WB) begin
			k_q <= '0;
		end
	end

	assign m_tdata = {2'b00, o_im_q, o_re_q, o_bin_q};
	assign m_tlast = o_last_q;

endmodule

FILE: rtl/real_sequence_fft_unit.sv
// Samples are taken one per cycle while loading, unless the job queue is full or the
// previous frame is not yet packed by the back end; a frame closes on its last sample.
// Compute per frame: pack, butterflies on one shared butterfly unit, split, N emitted bins.
// The next frame loads while the previous one is in butterflies, split or output.
// Reset (arst_n low, asynchronous) clears control state and sets frame_order to 63;
// sample, work and spectrum memories are not cleared.
module real_sequence_fft_unit #(
	parameter int N_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [5:0] bin_index, [29:6] real_part, [53:30] imag_part
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data   // [5:0] frame_order
);
	import rsf_pkg::*;

	localparam int AW = $clog2(N_POINTS);

	job_t             job_in, job_out;
	logic             job_push, q_full, q_empty, q_pop, frame_free;
	logic [AW-1:0]    smp_addr;
	logic [SMP_W-1:0] smp_data;

	rsf_front #(.N_POINTS(N_POINTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.job_push   (job_push),
		.job        (job_in),
		.q_full     (q_full),
		.frame_free (frame_free),
		.smp_addr   (smp_addr),
		.smp_data   (smp_data)
	);

	rsf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (job_out),
		.empty  (q_empty)
	);

	rsf_back #(.N_POINTS(N_POINTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.job        (job_out),
		.q_pop      (q_pop),
		.frame_free (frame_free),
		.smp_addr   (smp_addr),
		.smp_data   (smp_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: rtl/rsf_checker.sv
`include "assert_macros.svh"

module rsf_checker #(
	parameter int N_POINTS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	`RSF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`RSF_ASSERT_IMP(a_last_bin, m_tvalid && m_tlast, m_tdata[5:0] == 6'(N_POINTS - 1))
	`RSF_ASSERT_IMP(a_dc_real, m_tvalid && m_tdata[5:0] == 6'd0, m_tdata[53:30] == 24'd0)

endmodule

bind real_sequence_fft_unit rsf_checker #(.N_POINTS(N_POINTS)) u_rsf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: sim/tb_real_sequence_fft_unit.sv
`timescale 1ns / 1ps

module tb_real_sequence_fft_unit;
	import rsf_pkg::*;

	localparam int NBINS = 64;
	localparam int HALF = NBINS / 2;
	localparam int IDLE_WAIT = 700;
	localparam int WDOG_LIMIT = 6000;

	typedef struct {
		logic [5:0]         bin;
		logic signed [23:0] re;
		logic signed [23:0] im;
		logic               last;
	} bin_t;

	typedef struct {
		int          cfg;   // -1: no register write before this sample
		logic [15:0] smp;
		bit          flat;  // single-sample frame: every bin equals the sample, imag 0
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;

	real_sequence_fft_unit #(.N_POINTS(NBINS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	bin_t               spectrum_q[$];
	logic [15:0]        frame_smp[NBINS];
	logic [5:0]         order_reg;
	int                 fill_count;
	longint             wk_re[HALF];
	longint             wk_im[HALF];
	logic signed [23:0] bin_re[NBINS];
	logic signed [23:0] bin_im[NBINS];
	int                 errors;
	int                 n_samples;
	int                 n_bins;
	int                 n_frames;
	int                 tx_max;
	int                 rx_max;
	int                 quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint sin_q15(int n);
		int m;
		longint v;
		m = n & 63;
		v = (m & 16) ? QSINE[16 - (m & 15)] : QSINE[m & 15];
		return (m & 32) ? -v : v;
	endfunction

	function automatic longint rnd_shift(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [23:0] clip24(longint v);
		if (v > 8388607)
			return 24'sh7FFFFF;
		if (v < -8388608)
			return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic longint smp_at(int i, int len);
		if (i >= len)
			return 0;
		return longint'($signed(frame_smp[i]));
	endfunction

	// half-length complex FFT of the packed frame, then split into real-input bins
	task automatic compute_bins(int len);
		int rev, span, hlf, st, k, a, b, p;
		longint c, s, vr, vi, ur, ui, xt, yt, nr, ni;
		logic signed [23:0] r, m;
		for (int i = 0; i < HALF; i++) begin
			rev = 0;
			for (int j = 0; j < 5; j++)
				rev |= ((i >> j) & 1) << (4 - j);
			wk_re[rev] = smp_at(2 * i, len);
			wk_im[rev] = smp_at(2 * i + 1, len);
		end
		for (span = 2; span <= HALF; span <<= 1) begin
			hlf = span >> 1;
			for (st = 0; st < HALF; st += span) begin
				for (k = 0; k < hlf; k++) begin
					a = st + k;
					b = st + k + hlf;
					c = sin_q15(k * (64 / span) + 16);
					s = sin_q15(k * (64 / span));
					vr = rnd_shift(wk_re[b] * c + wk_im[b] * s, 15);
					vi = rnd_shift(wk_im[b] * c - wk_re[b] * s, 15);
					ur = wk_re[a];
					ui = wk_im[a];
					wk_re[a] = ur + vr;
					wk_im[a] = ui + vi;
					wk_re[b] = ur - vr;
					wk_im[b] = ui - vi;
				end
			end
		end
		bin_re[0] = clip24(wk_re[0] + wk_im[0]);
		bin_im[0] = '0;
		bin_re[HALF] = clip24(wk_re[0] - wk_im[0]);
		bin_im[HALF] = '0;
		for (int i = 1; i < HALF; i++) begin
			p = HALF - i;
			c = sin_q15(i + 16);
			s = sin_q15(i);
			xt = wk_re[i] - wk_re[p];
			yt = wk_im[i] + wk_im[p];
			nr = 32768 * (wk_re[i] + wk_re[p]) + c * yt - s * xt;
			ni = 32768 * (wk_im[p] - wk_im[i]) + s * yt + c * xt;
			r = clip24(rnd_shift(nr, 16));
			m = clip24(rnd_shift(ni, 16));
			bin_re[NBINS - i] = r;
			bin_im[NBINS - i] = m;
			bin_re[i] = r;
			bin_im[i] = (m == 24'sh800000) ? 24'sh7FFFFF : -m;
		end
	endtask

	task automatic take_sample(logic [15:0] v, bit flat);
		int len;
		bin_t e;
		len = int'(order_reg) + 1;
		if (fill_count < NBINS)
			frame_smp[fill_count] = v;
		fill_count++;
		if (fill_count < len)
			return;
		fill_count = 0;
		n_frames++;
		if (!flat)
			compute_bins(len);
		for (int k = 0; k < NBINS; k++) begin
			e.bin = k[5:0];
			e.re = flat ? 24'($signed(frame_smp[0])) : bin_re[k];
			e.im = flat ? 24'sd0 : bin_im[k];
			e.last = (k == NBINS - 1);
			spectrum_q.push_back(e);
		end
	endtask

	task automatic send_sample(logic [15:0] v, bit flat);
		int gap;
		gap = $urandom_range(tx_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		take_sample(v, flat);
		n_samples++;
	endtask

	task automatic write_order(logic [5:0] v);
		s_tvalid <= 1'b0;
		wait (spectrum_q.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		order_reg = v;
	endtask

	// receiver back-pressure
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(rx_max, 0);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		bin_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_bins++;
			if (spectrum_q.size() == 0) begin
				$error("unexpected bin transaction: bin_index %0d", m_tdata[5:0]);
				errors++;
			end else begin
				e = spectrum_q.pop_front();
				if (m_tdata[5:0] !== e.bin) begin
					$error("bin_index: expected %0d, got %0d", e.bin, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[29:6] !== e.re) begin
					$error("real_part: expected %0d, got %0d", e.re, $signed(m_tdata[29:6]));
					errors++;
				end
				if (m_tdata[53:30] !== e.im) begin
					$error("imag_part: expected %0d, got %0d", e.im, $signed(m_tdata[53:30]));
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("frame_end: expected %0d, got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", quiet);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	row_t dir_rows[$];

	initial begin
		int ord, frames, len;
		logic [15:0] v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		n_samples = 0;
		n_bins = 0;
		n_frames = 0;
		quiet = 0;
		order_reg = 6'd63;
		fill_count = 0;
		tx_max = 13;
		rx_max = 13;

		// single-sample frames: results readable directly
		dir_rows.push_back('{0, 16'h7FFF, 1});
		dir_rows.push_back('{-1, 16'h8000, 1});
		dir_rows.push_back('{-1, 16'h0000, 1});
		dir_rows.push_back('{-1, 16'h0001, 1});
		dir_rows.push_back('{-1, 16'hFFFF, 1});
		// short frames at the extremes
		dir_rows.push_back('{1, 16'h7FFF, 0});
		dir_rows.push_back('{-1, 16'h7FFF, 0});
		dir_rows.push_back('{-1, 16'h8000, 0});
		dir_rows.push_back('{-1, 16'h8000, 0});
		dir_rows.push_back('{3, 16'h7FFF, 0});
		dir_rows.push_back('{-1, 16'h8000, 0});
		dir_rows.push_back('{-1, 16'h7FFF, 0});
		dir_rows.push_back('{-1, 16'h8000, 0});
		// order lowered mid-frame: next sample closes on the first three
		dir_rows.push_back('{7, 16'h1234, 0});
		dir_rows.push_back('{-1, 16'hA5A5, 0});
		dir_rows.push_back('{-1, 16'h5A5A, 0});
		dir_rows.push_back('{-1, 16'h8001, 0});
		dir_rows.push_back('{-1, 16'h7FFE, 0});
		dir_rows.push_back('{2, 16'h4321, 0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg >= 0)
				write_order(6'(dir_rows[i].cfg));
			send_sample(dir_rows[i].smp, dir_rows[i].flat);
		end

		// random phases of whole frames
		for (int ph = 0; n_samples < 270; ph++) begin
			case (ph)
				0: ord = 63;
				1: ord = 0;
				2: ord = 62;
				default: ord = ($urandom_range(5, 0) == 0) ? $urandom_range(63, 0)
					: $urandom_range(15, 0);
			endcase
			write_order(6'(ord));
			tx_max = $urandom_range(3, 0) == 0 ? 0 : 13;
			rx_max = $urandom_range(3, 0) == 0 ? 0 : 13;
			len = ord + 1;
			frames = (len > 16) ? 1 : $urandom_range(4, 1);
			for (int f = 0; f < frames * len; f++) begin
				v = $urandom_range(65535, 0);
				if ($urandom_range(9, 0) == 0)
					v = $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
				send_sample(v, 0);
			end
		end
		s_tvalid <= 1'b0;
		tx_max = 13;
		rx_max = 13;

		wait (spectrum_q.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
		$display("covered %0d samples in %0d frames, %0d bins checked", n_samples,
			n_frames, n_bins);
		$display("frame lengths 1 to 64, extreme samples, order changed mid-frame");
		if (errors == 0 && spectrum_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/rsf_pkg.sv
rtl/rsf_front.sv
rtl/rsf_queue.sv
rtl/rsf_back.sv
rtl/real_sequence_fft_unit.sv
rtl/rsf_checker.sv
sim/tb_real_sequence_fft_unit.sv
